FILE: rtl/hitd_pkg.sv
// Package for the instruction-to-text block: the queue record type,
// ASCII codes and the mnemonic tables. It depends on nothing else.
`default_nettype none

package hitd_pkg;

	// ASCII codes used by the text sequencer
	localparam logic [6:0] CH_AT   = 7'h40;
	localparam logic [6:0] CH_EQ   = 7'h3D;
	localparam logic [6:0] CH_SEMI = 7'h3B;
	localparam logic [6:0] CH_NL   = 7'h0A;
	localparam logic [6:0] CH_ZERO = 7'h30;
	localparam logic [6:0] CH_PAD  = 7'h20;

	// Up to three characters, first character at index 0
	typedef logic [2:0][6:0] chr3_t;

	typedef struct packed {
		logic [1:0] len;
		chr3_t      chr;
	} txt_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic       is_addr;
		logic [14:0] value;
		logic [2:0] ndig;
		logic [2:0] dest;
		logic [1:0] comp_len;
		chr3_t      comp_chr;
		logic [2:0] jump;
	} hitd_rec_t;

	function automatic txt_t mk(input logic [1:0] n, input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2);
		txt_t t;
		t.len    = n;
		t.chr[0] = c0[6:0];
		t.chr[1] = c1[6:0];
		t.chr[2] = c2[6:0];
		return t;
	endfunction

	// Comp mnemonic; length zero for codes outside the table
	function automatic txt_t comp_txt(input logic [6:0] code);
		txt_t t;
		case (code)
			7'h2A: t = mk(2'd1, "0", " ", " ");
			7'h3F: t = mk(2'd1, "1", " ", " ");
			7'h3A: t = mk(2'd2, "-", "1", " ");
			7'h0C: t = mk(2'd1, "D", " ", " ");
			7'h30: t = mk(2'd1, "A", " ", " ");
			7'h0D: t = mk(2'd2, "!", "D", " ");
			7'h31: t = mk(2'd2, "!", "A", " ");
			7'h0F: t = mk(2'd2, "-", "D", " ");
			7'h33: t = mk(2'd2, "-", "A", " ");
			7'h1F: t = mk(2'd3, "D", "+", "1");
			7'h37: t = mk(2'd3, "A", "+", "1");
			7'h0E: t = mk(2'd3, "D", "-", "1");
			7'h32: t = mk(2'd3, "A", "-", "1");
			7'h02: t = mk(2'd3, "D", "+", "A");
			7'h13: t = mk(2'd3, "D", "-", "A");
			7'h07: t = mk(2'd3, "A", "-", "D");
			7'h00: t = mk(2'd3, "D", "&", "A");
			7'h15: t = mk(2'd3, "D", "|", "A");
			7'h70: t = mk(2'd1, "M", " ", " ");
			7'h71: t = mk(2'd2, "!", "M", " ");
			7'h73: t = mk(2'd2, "-", "M", " ");
			7'h77: t = mk(2'd3, "M", "+", "1");
			7'h72: t = mk(2'd3, "M", "-", "1");
			7'h42: t = mk(2'd3, "D", "+", "M");
			7'h53: t = mk(2'd3, "D", "-", "M");
			7'h47: t = mk(2'd3, "M", "-", "D");
			7'h40: t = mk(2'd3, "D", "&", "M");
			7'h55: t = mk(2'd3, "D", "|", "M");
			default: t = mk(2'd0, " ", " ", " ");
		endcase
		return t;
	endfunction

	// Dest register names
	function automatic txt_t dest_txt(input logic [2:0] dest);
		txt_t t;
		case (dest)
			3'd1: t = mk(2'd1, "M", " ", " ");
			3'd2: t = mk(2'd1, "D", " ", " ");
			3'd3: t = mk(2'd2, "M", "D", " ");
			3'd4: t = mk(2'd1, "A", " ", " ");
			3'd5: t = mk(2'd2, "A", "M", " ");
			3'd6: t = mk(2'd2, "A", "D", " ");
			3'd7: t = mk(2'd3, "A", "M", "D");
			default: t = mk(2'd0, " ", " ", " ");
		endcase
		return t;
	endfunction

	// Jump conditions, always three characters when present
	function automatic txt_t jump_txt(input logic [2:0] jump);
		txt_t t;
		case (jump)
			3'd1: t = mk(2'd3, "J", "G", "T");
			3'd2: t = mk(2'd3, "J", "E", "Q");
			3'd3: t = mk(2'd3, "J", "G", "E");
			3'd4: t = mk(2'd3, "J", "L", "T");
			3'd5: t = mk(2'd3, "J", "N", "E");
			3'd6: t = mk(2'd3, "J", "L", "E");
			3'd7: t = mk(2'd3, "J", "M", "P");
			default: t = mk(2'd0, " ", " ", " ");
		endcase
		return t;
	endfunction

	// Weight of the digit at a position counted from one at the right
	function automatic logic [13:0] pow10(input logic [2:0] pos);
		logic [13:0] p;
		case (pos)
			3'd1: p = 14'd1;
			3'd2: p = 14'd10;
			3'd3: p = 14'd100;
			3'd4: p = 14'd1000;
			3'd5: p = 14'd10000;
			default: p = 14'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/hack_instruction_to_text.sv
// Top level of the instruction-to-text block: front end, queue, back end.
// Depends on hitd_pkg, hitd_front, hitd_queue and hitd_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------
//   input    | start high, busy low   | instruction_word[15:0]
//   result   | strobe high, one cycle | out_char[6:0], last_char
//
// An item yields 1 to 12 characters, one per cycle; the next item follows with no
// gap when it is already waiting in the queue.
// An item is queued, then loaded by the sequencer, which registers its output.
// busy is high while the queue of QDEPTH classified items is full.
// Reset clears the queue and the sequencer; results cannot be stalled.
`default_nettype none

module hack_instruction_to_text #(
	parameter int QDEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] instruction_word,
	output logic             strobe,
	output logic [6:0]       out_char,
	output logic             last_char
);
	import hitd_pkg::*;

	hitd_rec_t push_rec;
	hitd_rec_t head_rec;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;

	hitd_front u_front (
		.start            (start),
		.full             (full),
		.instruction_word (instruction_word),
		.busy             (busy),
		.push             (push),
		.push_rec         (push_rec)
	);

	hitd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.full     (full),
		.empty    (empty)
	);

	hitd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head_rec  (head_rec),
		.pop       (pop),
		.strobe    (strobe),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

`default_nettype wire

FILE: rtl/hitd_front.sv
// Front end: accepts instruction words and classifies them into queue records.
// Depends on hitd_pkg for the record type and the comp table.
`default_nettype none

module hitd_front (
	input  wire logic              start,
	input  wire logic              full,
	input  wire logic [15:0]       instruction_word,
	output logic                   busy,
	output logic                   push,
	output hitd_pkg::hitd_rec_t    push_rec
);
	import hitd_pkg::*;

	txt_t        comp_t;
	logic [14:0] val;

	assign busy = full;
	assign push = start && !full;
	assign val  = instruction_word[14:0];
	assign comp_t = comp_txt(instruction_word[12:6]);

	// Classify: form, digit count, resolved comp mnemonic
	always_comb begin
		push_rec.is_addr  = !instruction_word[15];
		push_rec.value    = val;
		if (val < 15'd10) begin
			push_rec.ndig = 3'd1;
		end else if (val < 15'd100) begin
			push_rec.ndig = 3'd2;
		end else if (val < 15'd1000) begin
			push_rec.ndig = 3'd3;
		end else if (val < 15'd10000) begin
			push_rec.ndig = 3'd4;
		end else begin
			push_rec.ndig = 3'd5;
		end
		push_rec.dest     = instruction_word[5:3];
		push_rec.comp_len = comp_t.len;
		push_rec.comp_chr = comp_t.chr;
		push_rec.jump     = instruction_word[2:0];
	end

endmodule

`default_nettype wire

FILE: rtl/hitd_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on hitd_pkg for the record type.
`default_nettype none

module hitd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire hitd_pkg::hitd_rec_t push_rec,
	input  wire logic              pop,
	output hitd_pkg::hitd_rec_t    head_rec,
	output logic                   full,
	output logic                   empty
);
	import hitd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hitd_rec_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_rec = mem_q[rd_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/hitd_back.sv
// Back end: walks the text segments of one item and emits a character a cycle.
// Depends on hitd_pkg for the record type, ASCII codes and name tables.
`default_nettype none

module hitd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              empty,
	input  wire hitd_pkg::hitd_rec_t head_rec,
	output logic                   pop,
	output logic                   strobe,
	output logic [6:0]             out_char,
	output logic                   last_char
);
	import hitd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DEST, S_EQ, S_COMP, S_SEMI, S_JUMP, S_AT, S_DIG, S_NL
	} state_t;

	state_t      state_q;
	state_t      after_eq;
	state_t      first_st;
	hitd_rec_t   rec_q;
	logic [1:0]  idx_q;
	logic [2:0]  pos_q;
	logic [14:0] rem_q;
	logic [6:0]  ch;
	logic        seg_done;
	logic [13:0] pw;
	logic [3:0]  digit;
	logic [17:0] sub;
	txt_t        dest_t;
	txt_t        jump_t;

	assign dest_t = dest_txt(rec_q.dest);
	assign jump_t = jump_txt(rec_q.jump);
	assign pw     = pow10(pos_q);

	// Extract the leading digit: count multiples of the weight not above the rest
	always_comb begin
		digit = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({3'b000, rem_q} >= 18'(k) * {4'b0000, pw}) begin
				digit = 4'(k);
			end
		end
		sub = {14'b0, digit} * {4'b0000, pw};
	end

	// Segment that follows the dest part
	always_comb begin
		if (rec_q.comp_len != 2'd0) begin
			after_eq = S_COMP;
		end else if (rec_q.jump != 3'd0) begin
			after_eq = S_SEMI;
		end else begin
			after_eq = S_NL;
		end
	end

	// First segment of the item at the queue head
	always_comb begin
		if (head_rec.is_addr) begin
			first_st = S_AT;
		end else if (head_rec.dest != 3'd0) begin
			first_st = S_DEST;
		end else if (head_rec.comp_len != 2'd0) begin
			first_st = S_COMP;
		end else if (head_rec.jump != 3'd0) begin
			first_st = S_SEMI;
		end else begin
			first_st = S_NL;
		end
	end

	// Character of the current cycle and end of segment
	always_comb begin
		ch       = CH_NL;
		seg_done = 1'b1;
		case (state_q)
			S_DEST: begin
				ch       = dest_t.chr[idx_q];
				seg_done = (idx_q == dest_t.len - 2'd1);
			end
			S_EQ:   ch = CH_EQ;
			S_COMP: begin
				ch       = rec_q.comp_chr[idx_q];
				seg_done = (idx_q == rec_q.comp_len - 2'd1);
			end
			S_SEMI: ch = CH_SEMI;
			S_JUMP: begin
				ch       = jump_t.chr[idx_q];
				seg_done = (idx_q == 2'd2);
			end
			S_AT:   ch = CH_AT;
			S_DIG: begin
				ch       = CH_ZERO + {3'b000, digit};
				seg_done = (pos_q == 3'd1);
			end
			S_NL:   ch = CH_NL;
			default: ch = CH_PAD;
		endcase
	end

	assign pop = (state_q == S_IDLE || state_q == S_NL) && !empty;

	// Hold state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			strobe    <= 1'b0;
			last_char <= 1'b0;
			out_char  <= '0;
			rec_q     <= '0;
			rem_q     <= '0;
			idx_q     <= '0;
			pos_q     <= '0;
		end else begin
			strobe    <= (state_q != S_IDLE);
			last_char <= (state_q == S_NL);
			out_char  <= ch;
			if (pop) begin
				rec_q   <= head_rec;
				rem_q   <= head_rec.value;
				pos_q   <= head_rec.ndig;
				idx_q   <= '0;
				state_q <= first_st;
			end else begin
				idx_q <= seg_done ? 2'd0 : idx_q + 2'd1;
				if (state_q == S_DIG) begin
					rem_q <= rem_q - sub[14:0];
					pos_q <= pos_q - 3'd1;
				end
				if (seg_done) begin
					case (state_q)
						S_DEST: state_q <= S_EQ;
						S_EQ:   state_q <= after_eq;
						S_COMP: state_q <= (rec_q.jump != 3'd0) ? S_SEMI : S_NL;
						S_SEMI: state_q <= S_JUMP;
						S_JUMP: state_q <= S_NL;
						S_AT:   state_q <= S_DIG;
						S_DIG:  state_q <= S_NL;
						S_NL:   state_q <= S_IDLE;
						default: state_q <= S_IDLE;
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: dv/tb_hack_instruction_to_text.sv
// Testbench for hack_instruction_to_text: drives instruction words, predicts
// the text line of each and checks every character as it streams out.
// Depends on rtl/hitd_pkg.sv and the RTL under rtl/.
`default_nettype none

module tb_hack_instruction_to_text;

	import hitd_pkg::CH_NL;

	localparam int LIMIT       = 100000;
	localparam int SETTLE      = 24;
	localparam int RANDOM_HALF = 70;

	// Comp field codes (a-bit and c1..c6)
	localparam logic [6:0] COMP_ZERO    = 7'h2A;
	localparam logic [6:0] COMP_ONE     = 7'h3F;
	localparam logic [6:0] COMP_NEG_ONE = 7'h3A;
	localparam logic [6:0] COMP_D       = 7'h0C;
	localparam logic [6:0] COMP_A       = 7'h30;
	localparam logic [6:0] COMP_NOT_D   = 7'h0D;
	localparam logic [6:0] COMP_NOT_A   = 7'h31;
	localparam logic [6:0] COMP_NEG_D   = 7'h0F;
	localparam logic [6:0] COMP_NEG_A   = 7'h33;
	localparam logic [6:0] COMP_D_INC   = 7'h1F;
	localparam logic [6:0] COMP_A_INC   = 7'h37;
	localparam logic [6:0] COMP_D_DEC   = 7'h0E;
	localparam logic [6:0] COMP_A_DEC   = 7'h32;
	localparam logic [6:0] COMP_D_ADD_A = 7'h02;
	localparam logic [6:0] COMP_D_SUB_A = 7'h13;
	localparam logic [6:0] COMP_A_SUB_D = 7'h07;
	localparam logic [6:0] COMP_D_AND_A = 7'h00;
	localparam logic [6:0] COMP_D_OR_A  = 7'h15;
	localparam logic [6:0] COMP_M       = 7'h70;
	localparam logic [6:0] COMP_NOT_M   = 7'h71;
	localparam logic [6:0] COMP_NEG_M   = 7'h73;
	localparam logic [6:0] COMP_M_INC   = 7'h77;
	localparam logic [6:0] COMP_M_DEC   = 7'h72;
	localparam logic [6:0] COMP_D_ADD_M = 7'h42;
	localparam logic [6:0] COMP_D_SUB_M = 7'h53;
	localparam logic [6:0] COMP_M_SUB_D = 7'h47;
	localparam logic [6:0] COMP_D_AND_M = 7'h40;
	localparam logic [6:0] COMP_D_OR_M  = 7'h55;
	localparam logic [6:0] COMP_UNKNOWN = 7'h7F;

	localparam logic [6:0] KNOWN_COMPS [28] = '{
		COMP_ZERO, COMP_ONE, COMP_NEG_ONE, COMP_D, COMP_A, COMP_NOT_D, COMP_NOT_A,
		COMP_NEG_D, COMP_NEG_A, COMP_D_INC, COMP_A_INC, COMP_D_DEC, COMP_A_DEC,
		COMP_D_ADD_A, COMP_D_SUB_A, COMP_A_SUB_D, COMP_D_AND_A, COMP_D_OR_A,
		COMP_M, COMP_NOT_M, COMP_NEG_M, COMP_M_INC, COMP_M_DEC, COMP_D_ADD_M,
		COMP_D_SUB_M, COMP_M_SUB_D, COMP_D_AND_M, COMP_D_OR_M
	};

	localparam logic [2:0] DEST_NONE = 3'd0;
	localparam logic [2:0] DEST_M    = 3'd1;
	localparam logic [2:0] DEST_AMD  = 3'd7;
	localparam logic [2:0] JUMP_NONE = 3'd0;
	localparam logic [2:0] JUMP_JMP  = 3'd7;

	typedef struct {
		logic [6:0] ch;
		logic       last;
	} text_char_t;

	string dest_text [8] = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
	string jump_text [8] = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] instruction_word;
	logic        strobe;
	logic [6:0]  out_char;
	logic        last_char;

	text_char_t  line_q [$];
	int          n_items;
	int          n_addr;
	int          n_comp;
	int          n_chars;
	int          n_lines;
	int          n_errors;
	int          cycles;
	int          burst_left;

	hack_instruction_to_text dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.instruction_word (instruction_word),
		.strobe           (strobe),
		.out_char         (out_char),
		.last_char        (last_char)
	);

	// Toggle the clock, 12 units per period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Map a comp code to its mnemonic; unknown codes give no text
	function automatic string comp_mnemonic(input logic [6:0] code);
		case (code)
			COMP_ZERO:    return "0";
			COMP_ONE:     return "1";
			COMP_NEG_ONE: return "-1";
			COMP_D:       return "D";
			COMP_A:       return "A";
			COMP_NOT_D:   return "!D";
			COMP_NOT_A:   return "!A";
			COMP_NEG_D:   return "-D";
			COMP_NEG_A:   return "-A";
			COMP_D_INC:   return "D+1";
			COMP_A_INC:   return "A+1";
			COMP_D_DEC:   return "D-1";
			COMP_A_DEC:   return "A-1";
			COMP_D_ADD_A: return "D+A";
			COMP_D_SUB_A: return "D-A";
			COMP_A_SUB_D: return "A-D";
			COMP_D_AND_A: return "D&A";
			COMP_D_OR_A:  return "D|A";
			COMP_M:       return "M";
			COMP_NOT_M:   return "!M";
			COMP_NEG_M:   return "-M";
			COMP_M_INC:   return "M+1";
			COMP_M_DEC:   return "M-1";
			COMP_D_ADD_M: return "D+M";
			COMP_D_SUB_M: return "D-M";
			COMP_M_SUB_D: return "M-D";
			COMP_D_AND_M: return "D&M";
			COMP_D_OR_M:  return "D|M";
			default:      return "";
		endcase
	endfunction

	// Build the text line of one word and queue its characters
	function automatic void disassemble(input logic [15:0] word);
		string      line;
		logic [2:0] dest;
		logic [2:0] jump;
		byte        c;
		int         i;
		if (!word[15]) begin
			line = $sformatf("@%0d", word[14:0]);
		end else begin
			dest = word[5:3];
			jump = word[2:0];
			line = "";
			if (dest != DEST_NONE) line = {dest_text[dest], "="};
			line = {line, comp_mnemonic(word[12:6])};
			if (jump != JUMP_NONE) line = {line, ";", jump_text[jump]};
		end
		for (i = 0; i < line.len(); i++) begin
			c = line[i];
			line_q.push_back('{c[6:0], 1'b0});
		end
		line_q.push_back('{CH_NL, 1'b1});
	endfunction

	function automatic logic [15:0] compute_word(input logic [1:0] ignored,
			input logic [6:0] comp, input logic [2:0] dest, input logic [2:0] jump);
		return {1'b1, ignored, comp, dest, jump};
	endfunction

	// Pick an address with a random digit count, so short lines are common
	function automatic logic [15:0] random_address();
		logic [14:0] value;
		case ($urandom_range(1, 5))
			1: value = 15'($urandom_range(0, 9));
			2: value = 15'($urandom_range(10, 99));
			3: value = 15'($urandom_range(100, 999));
			4: value = 15'($urandom_range(1000, 9999));
			default: value = 15'($urandom_range(10000, 32767));
		endcase
		return {1'b0, value};
	endfunction

	// Mostly well-formed compute words, some with any comp code, some addresses
	function automatic logic [15:0] random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) return random_address();
		if (pick < 40) return {1'b1, 15'($urandom)};
		return compute_word(2'($urandom), KNOWN_COMPS[$urandom_range(0, 27)],
			3'($urandom), 3'($urandom));
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_word(input logic [15:0] word);
		start <= 1'b1;
		instruction_word <= word;
		@(posedge clk);
		while (busy) @(posedge clk);
		disassemble(word);
		n_items++;
		if (word[15]) n_comp++;
		else n_addr++;
	endtask

	// Drop start for a number of cycles, with noise on the word
	task automatic idle(input int n);
		if (n > 0) begin
			start <= 1'b0;
			instruction_word <= 16'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every queued character has come out
	task automatic drain();
		idle(1);
		while (line_q.size() != 0) @(posedge clk);
	endtask

	// Advance the burst pattern after an item
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle($urandom_range(1, 10));
			burst_left = $urandom_range(0, 11);
		end
	endtask

	task automatic test_address_form();
		send_word(16'h0000);
		send_word({1'b0, 15'd7});
		send_word({1'b0, 15'd10});
		send_word({1'b0, 15'd99});
		send_word({1'b0, 15'd100});
		send_word({1'b0, 15'd9999});
		send_word({1'b0, 15'd10000});
		send_word({1'b0, 15'd16384});
		send_word(16'h7FFF);
		idle(3);
	endtask

	task automatic test_compute_special();
		// unknown comp keeps dest and jump text
		send_word(compute_word(2'b00, COMP_UNKNOWN, DEST_M, JUMP_JMP));
		// unknown comp alone leaves only the newline
		send_word(compute_word(2'b00, COMP_UNKNOWN, DEST_NONE, JUMP_NONE));
		send_word(compute_word(2'b00, COMP_A_SUB_D, DEST_NONE, JUMP_NONE));
		// longest line, with and without the ignored bits
		send_word(compute_word(2'b00, COMP_D_INC, DEST_AMD, JUMP_JMP));
		send_word(compute_word(2'b11, COMP_D_INC, DEST_AMD, JUMP_JMP));
		send_word(16'hFFFF);
		send_word(16'h8000);
		idle(2);
	endtask

	task automatic test_comp_table();
		int i;
		for (i = 0; i < 28; i++) begin
			send_word(compute_word(2'($urandom), KNOWN_COMPS[i], 3'(i), 3'(i + 3)));
			pace();
		end
	endtask

	task automatic test_random_traffic(input int count, input int no_gap);
		int i;
		for (i = 0; i < count; i++) begin
			send_word(random_word());
			if (i >= no_gap) pace();
		end
	endtask

	task automatic test_drain_pause();
		int i;
		for (i = 0; i < 8; i++) send_word(random_word());
		drain();
		for (i = 0; i < 8; i++) send_word(random_word());
		idle(1);
	endtask

	// Compare each character with the oldest queued one
	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n && strobe) begin
			if (line_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected char expected none actual 0x%02h last=%0b",
					$realtime, out_char, last_char);
			end else begin
				want = line_q.pop_front();
				n_chars++;
				if (want.last) n_lines++;
				if (out_char !== want.ch) begin
					n_errors++;
					$display("%0t: out_char expected 0x%02h actual 0x%02h",
						$realtime, want.ch, out_char);
				end
				if (last_char !== want.last) begin
					n_errors++;
					$display("%0t: last_char expected %0b actual %0b",
						$realtime, want.last, last_char);
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles", $realtime, cycles);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		instruction_word = 16'h0000;
		n_items = 0;
		n_addr = 0;
		n_comp = 0;
		n_chars = 0;
		n_lines = 0;
		n_errors = 0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_address_form();
		test_compute_special();
		test_comp_table();
		test_random_traffic(RANDOM_HALF, 40);
		test_drain_pause();
		test_random_traffic(RANDOM_HALF, 0);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (line_q.size() != 0) begin
			n_errors++;
			$display("%0t: %0d chars never came out", $realtime, line_q.size());
		end
		$display("Sent %0d words (%0d address, %0d compute), all comp codes and dests",
			n_items, n_addr, n_comp);
		$display("Checked %0d chars in %0d lines, %0d errors", n_chars, n_lines, n_errors);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
